// ===== hw/rtl/tac_pkg.sv =====
package tac_pkg;

	// event codes
	localparam logic [2:0] OP_SAMPLE   = 3'd0;
	localparam logic [2:0] OP_SET      = 3'd1;
	localparam logic [2:0] OP_VIEW     = 3'd2;
	localparam logic [2:0] OP_INCREASE = 3'd3;
	localparam logic [2:0] OP_DECREASE = 3'd4;

	// read error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_RESET_FAIL = 2'd1;
	localparam logic [1:0] ERR_CRC        = 2'd2;
	localparam logic [1:0] ERR_INVALID    = 2'd3;

	// alarm codes
	localparam logic [1:0] ALARM_NORMAL = 2'd0;
	localparam logic [1:0] ALARM_OVER   = 2'd1;
	localparam logic [1:0] ALARM_UNDER  = 2'd2;

	localparam logic [9:0]  TEMP_MAX        = 10'd999;
	localparam logic [10:0] NUDGE           = 11'd5;
	localparam logic [8:0]  SIM_TOP         = 9'd400;
	localparam logic [8:0]  SIM_BOTTOM      = 9'd200;
	localparam logic [8:0]  SIM_STEP        = 9'd2;
	localparam logic [3:0]  FAIL_LIMIT      = 4'd10;
	localparam logic [15:0] CODE_RESET_FAIL = 16'hFFFF;
	localparam logic [15:0] CODE_CRC_ERR    = 16'hFFFE;
	localparam logic [9:0]  HIGH_RESET      = 10'd380;
	localparam logic [9:0]  LOW_RESET       = 10'd150;
	localparam logic [9:0]  TEMP_RESET      = 10'd200;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] sensor_reading;
	} tac_item_t;

	typedef struct packed {
		logic [9:0] temperature;
		logic [1:0] alarm_level;
		logic       editing;
		logic       edit_selects_low;
		logic [9:0] high_limit;
		logic [9:0] low_limit;
		logic       simulating;
		logic [1:0] read_error;
		logic       save_pulse;
		logic       sensor_dropped;
	} tac_result_t;

endpackage

// ===== hw/rtl/temperature_alarm_controller_core.sv =====
// Temperature alarm controller, all values in tenths of a degree. Each event beat (a sample
// tick or a key press) yields exactly one result beat. An event is captured in an input
// register, the state update and result are formed in one short combinational pass, and the
// result is held in an output register. One event per cycle is sustained while the output
// is not stalled by result_ready, set by that single update pass over the state registers.
// The event side keeps taking beats while a result waits, as long as the input stage can move
// into the output register. The sensor_present bit is written over the cfg channel, which is
// always ready, and should only be changed while no event is in flight.
module temperature_alarm_controller_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tac_pkg::tac_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output tac_pkg::tac_result_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	tac_pkg::tac_item_t   item_s1;
	logic                 valid_s1;
	tac_pkg::tac_result_t result_q;
	logic                 result_valid_q;
	logic                 advance;

	logic       present_q;
	logic [9:0] high_q, low_q, temp_q;
	logic [8:0] sim_q;
	logic       rising_q;
	logic [3:0] fail_q;
	logic       lost_q;
	logic       edit_q;
	logic       target_q;
	logic [1:0] alarm_q;

	logic [9:0] high_n, low_n, temp_n;
	logic [8:0] sim_n;
	logic       rising_n;
	logic [3:0] fail_n;
	logic       lost_n;
	logic       edit_n;
	logic       target_n;
	logic [1:0] alarm_n;
	logic [1:0] err_n;
	logic       save_n;
	logic       dropped_n;
	logic       simulate;
	logic [10:0] h, l;

	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;
	assign simulate     = !present_q || lost_q;

	always_comb begin
		high_n    = high_q;
		low_n     = low_q;
		temp_n    = temp_q;
		sim_n     = sim_q;
		rising_n  = rising_q;
		fail_n    = fail_q;
		lost_n    = lost_q;
		edit_n    = edit_q;
		target_n  = target_q;
		alarm_n   = alarm_q;
		err_n     = tac_pkg::ERR_NONE;
		save_n    = 1'b0;
		dropped_n = 1'b0;
		h         = {1'b0, high_q};
		l         = {1'b0, low_q};

		case (item_s1.opcode)
			tac_pkg::OP_SAMPLE: begin
				if (simulate) begin
					if (rising_q) begin
						if (sim_q + tac_pkg::SIM_STEP >= tac_pkg::SIM_TOP) begin
							sim_n    = tac_pkg::SIM_TOP;
							rising_n = 1'b0;
						end else begin
							sim_n = sim_q + tac_pkg::SIM_STEP;
						end
					end else if (sim_q > tac_pkg::SIM_BOTTOM) begin
						sim_n = sim_q - tac_pkg::SIM_STEP;
					end else begin
						sim_n    = tac_pkg::SIM_BOTTOM;
						rising_n = 1'b1;
					end
					temp_n = {1'b0, sim_n};
				end else if (item_s1.sensor_reading <= {6'd0, tac_pkg::TEMP_MAX}) begin
					temp_n = item_s1.sensor_reading[9:0];
					fail_n = '0;
				end else begin
					if (item_s1.sensor_reading == tac_pkg::CODE_RESET_FAIL) begin
						err_n = tac_pkg::ERR_RESET_FAIL;
					end else if (item_s1.sensor_reading == tac_pkg::CODE_CRC_ERR) begin
						err_n = tac_pkg::ERR_CRC;
					end else begin
						err_n = tac_pkg::ERR_INVALID;
					end
					// eleventh failure in a row drops the sensor
					if (fail_q >= tac_pkg::FAIL_LIMIT) begin
						lost_n    = 1'b1;
						fail_n    = '0;
						dropped_n = 1'b1;
					end else begin
						fail_n = fail_q + 4'd1;
					end
				end
				if (temp_n >= high_q) begin
					alarm_n = tac_pkg::ALARM_OVER;
				end else if (temp_n <= low_q) begin
					alarm_n = tac_pkg::ALARM_UNDER;
				end else begin
					alarm_n = tac_pkg::ALARM_NORMAL;
				end
			end
			tac_pkg::OP_SET: begin
				if (edit_q) begin
					edit_n = 1'b0;
					save_n = 1'b1;
				end
			end
			tac_pkg::OP_VIEW: begin
				if (!edit_q) begin
					edit_n   = 1'b1;
					target_n = 1'b0;
				end else begin
					target_n = !target_q;
				end
			end
			tac_pkg::OP_INCREASE, tac_pkg::OP_DECREASE: begin
				if (edit_q) begin
					if (!target_q) begin
						if (item_s1.opcode == tac_pkg::OP_INCREASE) begin
							if (h < {1'b0, tac_pkg::TEMP_MAX}) h = h + tac_pkg::NUDGE;
							if (h < l) h = l;
						end else if (h > l) begin
							h = (h > tac_pkg::NUDGE) ? h - tac_pkg::NUDGE : '0;
						end
					end else begin
						if (item_s1.opcode == tac_pkg::OP_INCREASE) begin
							if (l < h) l = l + tac_pkg::NUDGE;
							if (l > h) h = l;
						end else begin
							if (l > tac_pkg::NUDGE) l = l - tac_pkg::NUDGE;
							else l = '0;
							if (l > h) l = h;
						end
					end
					if (h > {1'b0, tac_pkg::TEMP_MAX}) h = {1'b0, tac_pkg::TEMP_MAX};
					if (l > {1'b0, tac_pkg::TEMP_MAX}) l = {1'b0, tac_pkg::TEMP_MAX};
					if (l > h) l = h;
					high_n = h[9:0];
					low_n  = l[9:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			present_q      <= 1'b0;
			high_q         <= tac_pkg::HIGH_RESET;
			low_q          <= tac_pkg::LOW_RESET;
			temp_q         <= tac_pkg::TEMP_RESET;
			sim_q          <= tac_pkg::SIM_BOTTOM;
			rising_q       <= 1'b1;
			fail_q         <= '0;
			lost_q         <= 1'b0;
			edit_q         <= 1'b0;
			target_q       <= 1'b0;
			alarm_q        <= tac_pkg::ALARM_NORMAL;
		end else begin
			if (cfg_valid && cfg_ready) present_q <= cfg_data;
			if (item_ready) valid_s1 <= item_valid;
			if (advance) begin
				result_valid_q <= 1'b1;
				high_q         <= high_n;
				low_q          <= low_n;
				temp_q         <= temp_n;
				sim_q          <= sim_n;
				rising_q       <= rising_n;
				fail_q         <= fail_n;
				lost_q         <= lost_n;
				edit_q         <= edit_n;
				target_q       <= target_n;
				alarm_q        <= alarm_n;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_s1 <= item;
		if (advance) begin
			result_q.temperature      <= temp_n;
			result_q.alarm_level      <= alarm_n;
			result_q.editing          <= edit_n;
			result_q.edit_selects_low <= target_n;
			result_q.high_limit       <= high_n;
			result_q.low_limit        <= low_n;
			result_q.simulating       <= !present_q || lost_n;
			result_q.read_error       <= err_n;
			result_q.save_pulse       <= save_n;
			result_q.sensor_dropped   <= dropped_n;
		end
	end

	// an empty output register never blocks the event side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item_ready)
		else $error("event side stalled with empty output register");

	a_limits_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.low_limit <= result_q.high_limit &&
			result_q.high_limit <= tac_pkg::TEMP_MAX))
		else $error("threshold order or range broken");

	a_dropped_sim: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.sensor_dropped |->
			result_q.simulating && result_q.read_error != tac_pkg::ERR_NONE)
		else $error("sensor drop without error or simulation");

	a_save_ends_edit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.save_pulse |-> !result_q.editing)
		else $error("save pulse while still editing");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import tac_pkg::*;

	// opcodes the block leaves undefined
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct {
		logic        cfg_write;
		logic        cfg_value;
		tac_item_t   ev;
		logic        known;
		tac_result_t want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	tac_item_t   item;
	logic        result_valid;
	logic        result_ready = 1'b0;
	tac_result_t result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// controller state as the testbench sees it
	logic [9:0] hi_thr      = HIGH_RESET;
	logic [9:0] lo_thr      = LOW_RESET;
	logic [9:0] cur_temp    = TEMP_RESET;
	logic [8:0] tri_value   = SIM_BOTTOM;
	logic       tri_rising  = 1'b1;
	logic [3:0] fail_run    = 4'd0;
	logic       sensor_gone = 1'b0;
	logic       edit_on     = 1'b0;
	logic       edit_low    = 1'b0;
	logic [1:0] alarm_now   = ALARM_NORMAL;
	logic       present_bit = 1'b0;

	tac_result_t expected_status_q [$];
	int          mismatch_count = 0;
	int          beats_sent     = 0;
	int          send_gap_pct   = 0;
	int          stall_pct      = 0;
	script_row_t script [23];

	temperature_alarm_controller_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic tac_result_t advance_controller(input tac_item_t ev);
		tac_result_t r;
		int h;
		int l;
		r = '0;
		case (ev.opcode)
			OP_SAMPLE: begin
				if (!present_bit || sensor_gone) begin
					if (tri_rising) begin
						tri_value = tri_value + SIM_STEP;
						if (tri_value >= SIM_TOP) begin
							tri_value = SIM_TOP;
							tri_rising = 1'b0;
						end
					end else if (tri_value > SIM_BOTTOM) begin
						tri_value = tri_value - SIM_STEP;
					end else begin
						tri_value = SIM_BOTTOM;
						tri_rising = 1'b1;
					end
					cur_temp = 10'(tri_value);
				end else if (ev.sensor_reading <= 16'(TEMP_MAX)) begin
					cur_temp = ev.sensor_reading[9:0];
					fail_run = 4'd0;
				end else begin
					fail_run = fail_run + 4'd1;
					if (ev.sensor_reading == CODE_RESET_FAIL) begin
						r.read_error = ERR_RESET_FAIL;
					end else if (ev.sensor_reading == CODE_CRC_ERR) begin
						r.read_error = ERR_CRC;
					end else begin
						r.read_error = ERR_INVALID;
					end
					if (fail_run > FAIL_LIMIT) begin
						sensor_gone = 1'b1;
						fail_run = 4'd0;
						r.sensor_dropped = 1'b1;
					end
				end
				if (cur_temp >= hi_thr) begin
					alarm_now = ALARM_OVER;
				end else if (cur_temp <= lo_thr) begin
					alarm_now = ALARM_UNDER;
				end else begin
					alarm_now = ALARM_NORMAL;
				end
			end
			OP_SET: begin
				if (edit_on) begin
					edit_on = 1'b0;
					r.save_pulse = 1'b1;
				end
			end
			OP_VIEW: begin
				if (!edit_on) begin
					edit_on = 1'b1;
					edit_low = 1'b0;
				end else begin
					edit_low = !edit_low;
				end
			end
			OP_INCREASE, OP_DECREASE: begin
				if (edit_on) begin
					h = hi_thr;
					l = lo_thr;
					if (!edit_low) begin
						if (ev.opcode == OP_INCREASE) begin
							if (h < TEMP_MAX) h = h + NUDGE;
							if (h < l) h = l;
						end else if (h > l) begin
							h = (h > NUDGE) ? h - NUDGE : 0;
						end
					end else begin
						if (ev.opcode == OP_INCREASE) begin
							if (l < h) l = l + NUDGE;
							if (l > h) h = l;
						end else begin
							if (l > 0) l = (l > NUDGE) ? l - NUDGE : 0;
							if (l > h) l = h;
						end
					end
					// clamp order matters: cap both, then keep low under high
					if (h > TEMP_MAX) h = TEMP_MAX;
					if (l > TEMP_MAX) l = TEMP_MAX;
					if (l > h) l = h;
					hi_thr = 10'(h);
					lo_thr = 10'(l);
				end
			end
			default: begin
			end
		endcase
		r.temperature      = cur_temp;
		r.alarm_level      = alarm_now;
		r.editing          = edit_on;
		r.edit_selects_low = edit_low;
		r.high_limit       = hi_thr;
		r.low_limit        = lo_thr;
		r.simulating       = !present_bit || sensor_gone;
		return r;
	endfunction

	function automatic tac_result_t steady_status(input logic [9:0] temp_v,
			input logic [1:0] alarm_v, input logic low_sel, input logic sim_v,
			input logic [1:0] err_v);
		tac_result_t r;
		r = '0;
		r.temperature      = temp_v;
		r.alarm_level      = alarm_v;
		r.edit_selects_low = low_sel;
		r.high_limit       = HIGH_RESET;
		r.low_limit        = LOW_RESET;
		r.simulating       = sim_v;
		r.read_error       = err_v;
		return r;
	endfunction

	function automatic logic [15:0] random_reading(input int err_pct);
		if ($urandom_range(0, 99) < err_pct) begin
			case ($urandom_range(0, 2))
				0: return CODE_RESET_FAIL;
				1: return CODE_CRC_ERR;
				default: return 16'($urandom_range(1000, 16'hFFFD));
			endcase
		end
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'(TEMP_MAX);
			2: return 16'(hi_thr);
			3: return 16'(lo_thr);
			4: return 16'(hi_thr) - 16'd1;
			5: return 16'(lo_thr) + 16'd1;
			default: return 16'($urandom_range(0, TEMP_MAX));
		endcase
	endfunction

	task automatic send_event(input tac_item_t ev, input logic known = 1'b0,
			input tac_result_t want = '0);
		tac_result_t predicted;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= ev;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predicted = advance_controller(ev);
		expected_status_q.push_back(known ? want : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	// only while nothing is in flight
	task automatic write_sensor_present(input logic value);
		item_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		present_bit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int beats, input int err_pct);
		int        start;
		int        pick;
		int        len;
		int        room;
		tac_item_t ev;
		start = beats_sent;
		while (beats_sent - start < beats) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				ev = '{OP_SAMPLE, random_reading(err_pct)};
				send_event(ev);
			end else if (pick < 80) begin
				// edit session: open, a few bursts of nudges, close with set
				ev = '{OP_VIEW, 16'($urandom)};
				send_event(ev);
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 2) == 0) begin
						ev = '{OP_VIEW, 16'($urandom)};
						send_event(ev);
					end
					// long runs push the thresholds into their clamps
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 210)
						: $urandom_range(1, 6);
					// keep runs within what the phase has left
					room = beats - (beats_sent - start);
					if (len > room) len = (room > 0) ? room : 1;
					ev.opcode = $urandom_range(0, 1) ? OP_INCREASE : OP_DECREASE;
					repeat (len) begin
						ev.sensor_reading = 16'($urandom);
						send_event(ev);
					end
					if ($urandom_range(0, 3) == 0) begin
						ev = '{OP_SAMPLE, random_reading(err_pct)};
						send_event(ev);
					end
				end
				ev = '{OP_SET, 16'($urandom)};
				send_event(ev);
			end else if (pick < 90) begin
				ev.opcode = (pick < 84) ? OP_SET : (pick < 87) ? OP_INCREASE : OP_DECREASE;
				ev.sensor_reading = 16'($urandom);
				send_event(ev);
			end else begin
				ev = '{3'($urandom_range(0, 7)), 16'($urandom)};
				send_event(ev);
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [9:0] want,
			input logic [9:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		tac_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_status_q.size() == 0) begin
				mismatch_count++;
				$display("%0t result beat with nothing expected: expected none, got %h",
					$time, result);
			end else begin
				want = expected_status_q.pop_front();
				compare_field("temperature", want.temperature, result.temperature);
				compare_field("alarm_level", want.alarm_level, result.alarm_level);
				compare_field("editing", want.editing, result.editing);
				compare_field("edit_selects_low", want.edit_selects_low,
					result.edit_selects_low);
				compare_field("high_limit", want.high_limit, result.high_limit);
				compare_field("low_limit", want.low_limit, result.low_limit);
				compare_field("simulating", want.simulating, result.simulating);
				compare_field("read_error", want.read_error, result.read_error);
				compare_field("save_pulse", want.save_pulse, result.save_pulse);
				compare_field("sensor_dropped", want.sensor_dropped, result.sensor_dropped);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;

		script = '{
			// simulation mode straight after reset, keys outside editing
			'{1'b1, 1'b0, '{OP_SET, 16'h0000}, 1'b1,
				steady_status(10'd200, ALARM_NORMAL, 1'b0, 1'b1, ERR_NONE)},
			'{1'b0, 1'b0, '{OP_INCREASE, 16'hFFFF}, 1'b1,
				steady_status(10'd200, ALARM_NORMAL, 1'b0, 1'b1, ERR_NONE)},
			'{1'b0, 1'b0, '{OP_DECREASE, 16'h0000}, 1'b1,
				steady_status(10'd200, ALARM_NORMAL, 1'b0, 1'b1, ERR_NONE)},
			'{1'b0, 1'b0, '{OP_SPARE7, 16'hFFFF}, 1'b1,
				steady_status(10'd200, ALARM_NORMAL, 1'b0, 1'b1, ERR_NONE)},
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'h0000}, 1'b1,
				steady_status(10'd202, ALARM_NORMAL, 1'b0, 1'b1, ERR_NONE)},
			// edit both thresholds and save
			'{1'b0, 1'b0, '{OP_VIEW, 16'h0000}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_INCREASE, 16'h0000}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_DECREASE, 16'h0000}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_VIEW, 16'h0000}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_DECREASE, 16'h0000}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_INCREASE, 16'h0000}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_SET, 16'h0000}, 1'b0, '0},
			// real sensor: reading extremes and each error code
			'{1'b1, 1'b1, '{OP_SAMPLE, 16'd0}, 1'b1,
				steady_status(10'd0, ALARM_UNDER, 1'b1, 1'b0, ERR_NONE)},
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'd999}, 1'b1,
				steady_status(10'd999, ALARM_OVER, 1'b1, 1'b0, ERR_NONE)},
			'{1'b0, 1'b0, '{OP_SAMPLE, CODE_RESET_FAIL}, 1'b1,
				steady_status(10'd999, ALARM_OVER, 1'b1, 1'b0, ERR_RESET_FAIL)},
			'{1'b0, 1'b0, '{OP_SAMPLE, CODE_CRC_ERR}, 1'b1,
				steady_status(10'd999, ALARM_OVER, 1'b1, 1'b0, ERR_CRC)},
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'd1000}, 1'b1,
				steady_status(10'd999, ALARM_OVER, 1'b1, 1'b0, ERR_INVALID)},
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'h8000}, 1'b0, '0},
			// alarm boundaries sit on the thresholds themselves
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'd380}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'd150}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_SAMPLE, 16'd379}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_SPARE5, 16'h5555}, 1'b0, '0},
			'{1'b0, 1'b0, '{OP_SPARE6, 16'hAAAA}, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].cfg_write) write_sensor_present(script[i].cfg_value);
			send_event(script[i].ev, script[i].known, script[i].want);
		end

		random_phase(250, 10);
		write_sensor_present(1'b0);
		send_gap_pct = 61;
		random_phase(150, 10);
		write_sensor_present(1'b1);
		send_gap_pct = 0;
		stall_pct = 61;
		random_phase(200, 15);
		send_gap_pct = 6;
		stall_pct = 6;
		random_phase(150, 20);
		// mostly bad readings, long failure streaks drop the sensor for good
		send_gap_pct = 0;
		stall_pct = 0;
		random_phase(200, 85);
		write_sensor_present(1'b0);
		stall_pct = 61;
		random_phase(100, 50);

		item_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tac_pkg.sv
hw/rtl/temperature_alarm_controller_core.sv
sim/testbench.sv
